FILE: src/b2da_pkg.sv
package b2da_pkg;

  // Default operand width and input beat width
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Binary bits consumed by one double-dabble stage
  localparam int unsigned BITS_PER_STAGE = 4;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 8;

  localparam logic [CHAR_W-1:0]  CHAR_MINUS   = 8'h2d;
  // '0'..'9' are 0x30 | digit
  localparam logic [DIGIT_W-1:0] CHAR_ZERO_HI = 4'h3;

  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT  = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADJUST = 4'd3;

endpackage

FILE: src/b2da_mag.sv
module b2da_mag import b2da_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned PAD_W       = VALUE_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   signed_mode_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic                   neg_o,
  output logic [PAD_W-1:0]       mag_o
);

  logic                   valid_q;
  logic                   neg_q, neg_d;
  logic [PAD_W-1:0]       mag_q, mag_d;
  logic [VALUE_WIDTH-1:0] abs_c;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    neg_d = signed_mode_i && value_i[VALUE_WIDTH-1];
    // most negative value wraps to 2^(W-1), which is right when read unsigned
    abs_c = neg_d ? (~value_i + VALUE_WIDTH'(1)) : value_i;
    mag_d = PAD_W'(abs_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      neg_q <= neg_d;
      mag_q <= mag_d;
    end
  end

  assign valid_o = valid_q;
  assign neg_o   = neg_q;
  assign mag_o   = mag_q;

endmodule

FILE: src/b2da_dabble.sv
module b2da_dabble import b2da_pkg::*; #(
  parameter int unsigned BIN_W = 32,
  parameter int unsigned BCD_W = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic             neg_i,
  input  logic [BCD_W-1:0] bcd_i,
  input  logic [BIN_W-1:0] bin_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic             neg_o,
  output logic [BCD_W-1:0] bcd_o,
  output logic [BIN_W-1:0] bin_o
);

  localparam int unsigned NumDigits = BCD_W / DIGIT_W;

  logic             valid_q;
  logic             neg_q;
  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic [BIN_W-1:0] bin_q, bin_d;

  assign ready_o = !valid_q || ready_i;

  // shift-add-3, BITS_PER_STAGE bits per stage
  always_comb begin
    bcd_d = bcd_i;
    bin_d = bin_i;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (bcd_d[d*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT) begin
          bcd_d[d*DIGIT_W +: DIGIT_W] = bcd_d[d*DIGIT_W +: DIGIT_W] + DABBLE_ADJUST;
        end
      end
      bcd_d = {bcd_d[BCD_W-2:0], bin_d[BIN_W-1]};
      bin_d = {bin_d[BIN_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      neg_q <= neg_i;
      bcd_q <= bcd_d;
      bin_q <= bin_d;
    end
  end

  assign valid_o = valid_q;
  assign neg_o   = neg_q;
  assign bcd_o   = bcd_q;
  assign bin_o   = bin_q;

endmodule

FILE: src/b2da_align.sv
module b2da_align import b2da_pkg::*; #(
  parameter int unsigned NUM_DIGITS = 10,
  parameter int unsigned CNT_W      = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic                          neg_i,
  input  logic [NUM_DIGITS*DIGIT_W-1:0] bcd_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic                          neg_o,
  output logic [NUM_DIGITS*DIGIT_W-1:0] bcd_o,
  output logic [CNT_W-1:0]              cnt_o
);

  localparam int unsigned BcdW = NUM_DIGITS * DIGIT_W;

  logic             valid_q;
  logic             neg_q;
  logic [BcdW-1:0]  bcd_q, bcd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] shamt_c;

  assign ready_o = !valid_q || ready_i;

  // digit count without leading zeros (zero keeps one digit), then left-justify
  always_comb begin
    cnt_d = CNT_W'(1);
    for (int d = 1; d < NUM_DIGITS; d++) begin
      if (bcd_i[d*DIGIT_W +: DIGIT_W] != '0) begin
        cnt_d = CNT_W'(d + 1);
      end
    end
    shamt_c = CNT_W'(NUM_DIGITS) - cnt_d;
    bcd_d   = bcd_i << {shamt_c, 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      neg_q <= neg_i;
      bcd_q <= bcd_d;
      cnt_q <= cnt_d;
    end
  end

  assign valid_o = valid_q;
  assign neg_o   = neg_q;
  assign bcd_o   = bcd_q;
  assign cnt_o   = cnt_q;

endmodule

FILE: src/b2da_serial.sv
module b2da_serial import b2da_pkg::*; #(
  parameter int unsigned NUM_DIGITS = 10,
  parameter int unsigned CNT_W      = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic                          neg_i,
  input  logic [NUM_DIGITS*DIGIT_W-1:0] bcd_i,
  input  logic [CNT_W-1:0]              cnt_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [CHAR_W-1:0]             char_o,
  output logic                          last_o
);

  localparam int unsigned BcdW = NUM_DIGITS * DIGIT_W;

  logic             valid_q;
  logic             sgn_q;
  logic [BcdW-1:0]  sh_q;
  logic [CNT_W-1:0] cnt_q;
  logic             beat;

  assign beat    = valid_q && ready_i;
  // next number loads in the cycle its predecessor's last beat leaves
  assign ready_o = !valid_q || (ready_i && last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      sgn_q <= neg_i;
      sh_q  <= bcd_i;
      cnt_q <= cnt_i;
    end else if (beat) begin
      if (sgn_q) begin
        sgn_q <= 1'b0;
      end else begin
        sh_q  <= sh_q << DIGIT_W;
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  assign valid_o = valid_q;
  assign char_o  = sgn_q ? CHAR_MINUS : {CHAR_ZERO_HI, sh_q[BcdW-1 -: DIGIT_W]};
  assign last_o  = !sgn_q && (cnt_q == CNT_W'(1));

endmodule

FILE: src/binary_to_decimal_ascii_unit.sv
// Channel  | Dir | tdata                          | tuser        | tlast
// s_axis   | in  | value [VALUE_WIDTH-1:0], pad   | signed_mode  | -
// m_axis   | out | character [7:0]                | -            | last
//
// Pipeline: magnitude stage, ceil(VALUE_WIDTH/4) double-dabble stages, align
// stage, then the character serializer. The serializer sends one character a
// cycle while m_axis_tready is high; a number is 1 to 11 characters (digits
// plus minus sign) at VALUE_WIDTH = 32.
// Reset clears all stage valid bits. Backpressure runs stage by stage through
// per-stage ready; nothing is dropped or repeated under stalls.
module binary_to_decimal_ascii_unit import b2da_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata, // value
  input  logic                            s_axis_tuser,  // signed_mode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [CHAR_W-1:0]               m_axis_tdata,  // character
  output logic                            m_axis_tlast   // last
);

  localparam int unsigned NumStages = (VALUE_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int unsigned PadW      = NumStages * BITS_PER_STAGE;
  localparam int unsigned NumDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned BcdW      = NumDigits * DIGIT_W;
  localparam int unsigned CntW      = $clog2(NumDigits + 1);

  logic [NumStages:0] stg_valid;
  logic [NumStages:0] stg_ready;
  logic [NumStages:0] stg_neg;
  logic [BcdW-1:0]    stg_bcd [NumStages+1];
  logic [PadW-1:0]    stg_bin [NumStages+1];

  logic             aln_valid, aln_ready, aln_neg;
  logic [BcdW-1:0]  aln_bcd;
  logic [CntW-1:0]  aln_cnt;

  b2da_mag #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .PAD_W      (PadW)
  ) u_mag (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .value_i      (s_axis_tdata[VALUE_WIDTH-1:0]),
    .signed_mode_i(s_axis_tuser),
    .valid_o      (stg_valid[0]),
    .ready_i      (stg_ready[0]),
    .neg_o        (stg_neg[0]),
    .mag_o        (stg_bin[0])
  );

  assign stg_bcd[0] = '0;

  for (genvar g = 0; g < NumStages; g++) begin : g_dabble
    b2da_dabble #(
      .BIN_W(PadW),
      .BCD_W(BcdW)
    ) u_dabble (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(stg_valid[g]),
      .ready_o(stg_ready[g]),
      .neg_i  (stg_neg[g]),
      .bcd_i  (stg_bcd[g]),
      .bin_i  (stg_bin[g]),
      .valid_o(stg_valid[g+1]),
      .ready_i(stg_ready[g+1]),
      .neg_o  (stg_neg[g+1]),
      .bcd_o  (stg_bcd[g+1]),
      .bin_o  (stg_bin[g+1])
    );
  end

  b2da_align #(
    .NUM_DIGITS(NumDigits),
    .CNT_W     (CntW)
  ) u_align (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(stg_valid[NumStages]),
    .ready_o(stg_ready[NumStages]),
    .neg_i  (stg_neg[NumStages]),
    .bcd_i  (stg_bcd[NumStages]),
    .valid_o(aln_valid),
    .ready_i(aln_ready),
    .neg_o  (aln_neg),
    .bcd_o  (aln_bcd),
    .cnt_o  (aln_cnt)
  );

  b2da_serial #(
    .NUM_DIGITS(NumDigits),
    .CNT_W     (CntW)
  ) u_serial (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(aln_valid),
    .ready_o(aln_ready),
    .neg_i  (aln_neg),
    .bcd_i  (aln_bcd),
    .cnt_i  (aln_cnt),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .char_o (m_axis_tdata),
    .last_o (m_axis_tlast)
  );

endmodule

FILE: src/b2da_checker.sv
module b2da_checker import b2da_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [CHAR_W-1:0] m_axis_tdata,
  input logic              m_axis_tlast
);

  localparam logic [CHAR_W-1:0] CharDigit0 = 8'h30;
  localparam logic [CHAR_W-1:0] CharDigit9 = 8'h39;

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata == CHAR_MINUS) ||
      (m_axis_tdata >= CharDigit0 && m_axis_tdata <= CharDigit9))
    else $error("character is neither sign nor digit");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata == CHAR_MINUS |-> !m_axis_tlast)
    else $error("minus sign marked last");

  // a number is sent without gaps and a sign is followed by a digit
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a number");

  a_digit_after_minus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tdata == CHAR_MINUS |=>
      m_axis_tdata != CHAR_MINUS)
    else $error("two signs in a row");

endmodule

bind binary_to_decimal_ascii_unit b2da_checker u_b2da_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

FILE: tb/b2da_stream_checker.sv
`timescale 1ns / 100ps

module b2da_stream_checker import b2da_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned DATA_W      = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,  // value, pad
  input  logic              s_axis_tuser,  // signed_mode
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [CHAR_W-1:0] m_axis_tdata,  // character
  input  logic              m_axis_tlast,
  output int                fail_count_o,
  output int                pending_o
);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
  localparam int unsigned       RADIX      = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_char_t;

  text_char_t expected_text[$];
  int         mismatches;

  // Queue the decimal text of one number, sign first, most significant digit next
  task automatic push_decimal(input logic [VALUE_WIDTH-1:0] num, input logic as_signed);
    logic [VALUE_WIDTH-1:0] mag;
    logic [DIGIT_W-1:0]     digits[$];
    logic                   neg;
    text_char_t             tc;
    neg = as_signed && num[VALUE_WIDTH-1];
    mag = neg ? (~num + VALUE_WIDTH'(1)) : num;
    do begin
      digits.push_front(DIGIT_W'(mag % RADIX));
      mag = mag / RADIX;
    end while (mag != 0);
    if (neg) begin
      tc.character = CHAR_MINUS;
      tc.last      = 1'b0;
      expected_text.push_back(tc);
    end
    for (int i = 0; i < digits.size(); i++) begin
      tc.character = ASCII_ZERO + CHAR_W'(digits[i]);
      tc.last      = (i == digits.size() - 1);
      expected_text.push_back(tc);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t want;
    if (!rst_ni) begin
      expected_text.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        push_decimal(s_axis_tdata[VALUE_WIDTH-1:0], s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected output beat: character %0d last %0b", m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want = expected_text.pop_front();
          if (m_axis_tdata !== want.character) begin
            $error("character: expected %0d, got %0d", want.character, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
            mismatches++;
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_text.size();
    end
  end

endmodule

FILE: tb/binary_to_decimal_ascii_unit_tb.sv
`timescale 1ns / 100ps

module binary_to_decimal_ascii_unit_tb;
  import b2da_pkg::*;

  localparam int unsigned VALUE_WIDTH  = VALUE_WIDTH_DEF;
  localparam int unsigned DATA_W       = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int          RANDOM_ITEMS = 250;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          IDLE_PCT     = 17;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata;   // value, pad
  logic              s_axis_tuser;   // signed_mode
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [CHAR_W-1:0] m_axis_tdata;   // character
  logic              m_axis_tlast;

  int   fail_count;
  int   pending;
  int   cycle_count;
  logic idle_en;
  logic hold_req;

  binary_to_decimal_ascii_unit #(.VALUE_WIDTH(VALUE_WIDTH)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  b2da_stream_checker #(.VALUE_WIDTH(VALUE_WIDTH)) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one number; returns at the edge where the beat is taken
  task automatic send_number(input logic [VALUE_WIDTH-1:0] num, input logic as_signed);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_W'(num);
    s_axis_tuser  <= as_signed;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [VALUE_WIDTH-1:0] random_number();
    logic [VALUE_WIDTH-1:0] p10;
    int                     k;
    case ($urandom_range(4))
      0, 1: random_number = $urandom();
      2: random_number = $urandom() >> $urandom_range(VALUE_WIDTH - 1);
      3: random_number = $urandom_range(999);
      default: begin
        // land around a power of ten to flip the digit count
        p10 = 1;
        k = $urandom_range(9);
        for (int i = 0; i < k; i++) p10 = p10 * 10;
        random_number = p10 + $urandom_range(2) - 1;
        if ($urandom_range(1)) random_number = -random_number;
      end
    endcase
  endfunction

  // Sink side: random stalls plus one long hold-off on request
  initial begin
    int  hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin
    logic [VALUE_WIDTH-1:0] num;
    cycle_count   = 0;
    rst_ni        = 1'b0;
    idle_en       <= 1'b1;
    hold_req      <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero in both modes, extremes, sign boundary, digit-count edges
    send_number(32'd0, 1'b0);
    send_number(32'd0, 1'b1);
    send_number(32'd1, 1'b0);
    send_number(32'd9, 1'b1);
    send_number(32'd10, 1'b0);
    send_number(32'hFFFF_FFFF, 1'b0);
    send_number(32'hFFFF_FFFF, 1'b1);
    send_number(32'h8000_0000, 1'b1);
    send_number(32'h8000_0000, 1'b0);
    send_number(32'h7FFF_FFFF, 1'b1);
    send_number(32'h7FFF_FFFF, 1'b0);
    send_number(32'h8000_0001, 1'b1);
    send_number(32'd999_999_999, 1'b0);
    send_number(32'd1_000_000_000, 1'b1);
    send_number(32'd4_000_000_000, 1'b0);
    send_number(32'd4_000_000_000, 1'b1);
    send_number(-32'd10, 1'b1);
    send_number(-32'd1_000_000_000, 1'b1);
    send_number(32'hAAAA_AAAA, 1'b0);
    send_number(32'h5555_5555, 1'b1);
    send_number(32'd100, 1'b1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 40) hold_req <= 1'b1;
      if (n == 150) idle_en <= 1'b0;
      if (n == 200) idle_en <= 1'b1;
      num = random_number();
      send_number(num, $urandom_range(1));
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
